>>> hw/rtl/tcw_pkg.sv
package tcw_pkg;

    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] RESET_ATTR     = 8'h0F;
    localparam logic [7:0] NEWLINE_CODE   = 8'd10;
    localparam logic [7:0] BACKSPACE_CODE = 8'd8;
    localparam logic [7:0] TAB_CODE       = 8'd9;
    localparam int         TAB_STEP       = 4;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef enum logic [10:0] {
        S_INIT   = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_EXEC   = 11'b000_0000_0100,
        S_SCR_RD = 11'b000_0000_1000,
        S_SCR_WR = 11'b000_0001_0000,
        S_FILL   = 11'b000_0010_0000,
        S_BS_RD  = 11'b000_0100_0000,
        S_BS_WR  = 11'b000_1000_0000,
        S_RD_RD  = 11'b001_0000_0000,
        S_RD_CAP = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

endpackage

>>> hw/rtl/text_console_writer_core.sv
// Text console engine holding COLUMNS x ROWS character/attribute cells in one
// single-port-write, registered-read memory, with a linear cursor. After reset
// a clearing pass writes every cell to a space with attribute 0x0F, and no
// transfer is accepted during that pass. One item is handled at a time by a
// small sequencer around the memory port. A printable character, newline or
// tab that does not scroll goes from EXEC straight to DONE, as do a backspace at
// the home position, a read outside the screen and the unused mode. A backspace
// that moves the cursor passes through BS_RD and BS_WR, a read inside the
// screen through RD_RD and RD_CAP, and a clear through FILL, which writes
// every cell. A put that scrolls alternates SCR_RD and SCR_WR, since every
// moved cell needs one read and one write on the memory port, and then blanks
// the bottom row in FILL. A finished result waits in an output register, so
// the next item can be accepted while it is still pending.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_cursor_row,
    output logic [6:0] o_cursor_col,
    output logic       o_scrolled,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int LIN_W = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [LIN_W-1:0]   r_lin, n_lin;
    logic [LIN_W-1:0]   r_addr, n_addr;
    logic               r_scr, n_scr;
    logic [7:0]         r_cell_char, n_cell_char;
    logic [7:0]         r_cell_attr, n_cell_attr;
    logic [7:0]         r_attr;
    logic [1:0]         r_mode;
    logic [7:0]         r_char;
    logic [4:0]         r_read_row;
    logic [6:0]         r_read_col;
    logic [15:0]        r_rdata;
    logic               r_out_valid;
    logic [4:0]         r_o_row;
    logic [6:0]         r_o_col;
    logic               r_o_scr;
    logic [7:0]         r_o_char;
    logic [7:0]         r_o_attr;

    logic [15:0]        mem [CELLS];
    logic               mem_we;
    logic [LIN_W-1:0]   mem_waddr;
    logic [15:0]        mem_wdata;
    logic               mem_re;
    logic [LIN_W-1:0]   mem_raddr;

    logic               col_last;
    logic               row_last;
    logic [COL_W:0]     tab_sum;
    logic               tab_wrap;
    logic               out_free;

    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign tab_sum  = {1'b0, r_col} + (COL_W + 1)'(TAB_STEP);
    assign tab_wrap = (tab_sum >= (COL_W + 1)'(COLUMNS));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_lin       = r_lin;
        n_addr      = r_addr;
        n_scr       = r_scr;
        n_cell_char = r_cell_char;
        n_cell_attr = r_cell_attr;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = {r_attr, BLANK_CHAR};
        mem_re      = 1'b0;
        mem_raddr   = r_addr;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                n_addr    = r_addr + LIN_W'(1);
                if (r_addr == LIN_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_scr       = 1'b0;
                n_cell_char = 8'd0;
                n_cell_attr = 8'd0;
                n_state     = S_DONE;
                case (r_mode)
                    MODE_PUT: begin
                        case (r_char)
                            NEWLINE_CODE: begin
                                n_col = '0;
                                n_row = r_row + ROW_W'(1);
                                n_lin = r_lin - LIN_W'(r_col) + LIN_W'(COLUMNS);
                                if (row_last) begin
                                    n_state = S_SCR_RD;
                                end
                            end
                            BACKSPACE_CODE: begin
                                if (r_lin != '0) begin
                                    n_lin   = r_lin - LIN_W'(1);
                                    n_addr  = r_lin - LIN_W'(1);
                                    n_state = S_BS_RD;
                                    if (r_col == '0) begin
                                        n_row = r_row - ROW_W'(1);
                                        n_col = COL_W'(COLUMNS - 1);
                                    end else begin
                                        n_col = r_col - COL_W'(1);
                                    end
                                end
                            end
                            TAB_CODE: begin
                                n_lin = r_lin + LIN_W'(TAB_STEP);
                                if (tab_wrap) begin
                                    n_row = r_row + ROW_W'(1);
                                    n_col = COL_W'(tab_sum - (COL_W + 1)'(COLUMNS));
                                    if (row_last) begin
                                        n_state = S_SCR_RD;
                                    end
                                end else begin
                                    n_col = tab_sum[COL_W-1:0];
                                end
                            end
                            default: begin
                                mem_we    = 1'b1;
                                mem_waddr = r_lin;
                                mem_wdata = {r_attr, r_char};
                                n_lin     = r_lin + LIN_W'(1);
                                if (col_last) begin
                                    n_col = '0;
                                    n_row = r_row + ROW_W'(1);
                                    if (row_last) begin
                                        n_state = S_SCR_RD;
                                    end
                                end else begin
                                    n_col = r_col + COL_W'(1);
                                end
                            end
                        endcase
                        if (n_state == S_SCR_RD) begin
                            n_scr  = 1'b1;
                            n_addr = '0;
                            n_row  = ROW_W'(ROWS - 1);
                            n_col  = '0;
                            n_lin  = LIN_W'(CELLS - COLUMNS);
                        end
                    end
                    MODE_CLEAR: begin
                        n_addr  = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_lin   = '0;
                        n_state = S_FILL;
                    end
                    MODE_READ: begin
                        if ((32'(r_read_row) < ROWS) && (32'(r_read_col) < COLUMNS)) begin
                            n_addr  = LIN_W'(32'(r_read_row) * COLUMNS + 32'(r_read_col));
                            n_state = S_RD_RD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCR_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr + LIN_W'(COLUMNS);
                n_state   = S_SCR_WR;
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_addr    = r_addr + LIN_W'(1);
                if (r_addr == LIN_W'(CELLS - COLUMNS - 1)) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_SCR_RD;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                n_addr = r_addr + LIN_W'(1);
                if (r_addr == LIN_W'(CELLS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_BS_RD: begin
                mem_re  = 1'b1;
                n_state = S_BS_WR;
            end
            S_BS_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {r_rdata[15:8], BLANK_CHAR};
                n_state   = S_DONE;
            end
            S_RD_RD: begin
                mem_re  = 1'b1;
                n_state = S_RD_CAP;
            end
            S_RD_CAP: begin
                n_cell_char = r_rdata[7:0];
                n_cell_attr = r_rdata[15:8];
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_lin       <= '0;
            r_addr      <= '0;
            r_attr      <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_lin   <= n_lin;
            r_addr  <= n_addr;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scr       <= n_scr;
        r_cell_char <= n_cell_char;
        r_cell_attr <= n_cell_attr;
        if (r_state == S_IDLE && i_in_valid) begin
            r_mode     <= i_mode;
            r_char     <= i_char_code;
            r_read_row <= i_read_row;
            r_read_col <= i_read_col;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_row  <= 5'(r_row);
            r_o_col  <= 7'(r_col);
            r_o_scr  <= r_scr;
            r_o_char <= r_cell_char;
            r_o_attr <= r_cell_attr;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_scrolled   = r_o_scr;
    assign o_cell_char  = r_o_char;
    assign o_cell_attr  = r_o_attr;

endmodule

>>> tb/tb_text_console_writer_core.sv
module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 450;
    localparam longint CYCLE_LIMIT =
        64'd4 * (3 * PHASE_ITEMS + 100) * (2 * CELLS + 300) + 64'd4 * CELLS;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } console_status_t;

    class console_shadow;
        logic [15:0]     cells [CELLS];
        int unsigned     cursor;
        logic [7:0]      attribute;
        console_status_t status_q[$];
        int unsigned     mismatches;
        int unsigned     checked;
        int unsigned     scrolls;
        int unsigned     clears;
        int unsigned     reads;

        function new();
            foreach (cells[i]) cells[i] = {RESET_ATTR, BLANK_CHAR};
            cursor = 0;
            attribute = RESET_ATTR;
            mismatches = 0;
            checked = 0;
            scrolls = 0;
            clears = 0;
            reads = 0;
        endfunction

        function void accept_command(logic [1:0] mode, logic [7:0] ch,
                                     logic [4:0] row, logic [6:0] col);
            console_status_t s;
            int unsigned i;
            s = '0;
            case (mode)
                MODE_PUT: begin
                    if (ch == NEWLINE_CODE) begin
                        cursor = (cursor / COLUMNS + 1) * COLUMNS;
                    end else if (ch == BACKSPACE_CODE) begin
                        if (cursor != 0) begin
                            cursor--;
                            cells[cursor][7:0] = BLANK_CHAR;
                        end
                    end else if (ch == TAB_CODE) begin
                        cursor += TAB_STEP;
                    end else begin
                        cells[cursor] = {attribute, ch};
                        cursor++;
                    end
                    if (cursor >= CELLS) begin
                        for (i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                        for (i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attribute, BLANK_CHAR};
                        cursor = CELLS - COLUMNS;
                        s.scrolled = 1'b1;
                        scrolls++;
                    end
                end
                MODE_CLEAR: begin
                    foreach (cells[k]) cells[k] = {attribute, BLANK_CHAR};
                    cursor = 0;
                    clears++;
                end
                MODE_READ: begin
                    reads++;
                    if (row < ROWS && col < COLUMNS)
                        {s.cell_attr, s.cell_char} = cells[row * COLUMNS + col];
                end
                default: begin
                end
            endcase
            s.cursor_row = 5'(cursor / COLUMNS);
            s.cursor_col = 7'(cursor % COLUMNS);
            status_q.push_back(s);
        endfunction

        function void flag(string what, console_status_t want, console_status_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected row %0d col %0d scrolled %0b char %02h attr %02h",
                         what, want.cursor_row, want.cursor_col, want.scrolled,
                         want.cell_char, want.cell_attr);
                $display("    got row %0d col %0d scrolled %0b char %02h attr %02h",
                         got.cursor_row, got.cursor_col, got.scrolled,
                         got.cell_char, got.cell_attr);
            end
        endfunction

        function void check_status(console_status_t got);
            console_status_t want;
            if (status_q.size() == 0) begin
                flag("Unexpected result transfer", '0, got);
            end else begin
                want = status_q.pop_front();
                checked++;
                if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
                    got.scrolled !== want.scrolled || got.cell_char !== want.cell_char ||
                    got.cell_attr !== want.cell_attr)
                    flag($sformatf("Result %0d differs", checked), want, got);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_mode = MODE_PUT;
    logic [7:0] i_char_code = 8'h00;
    logic [4:0] i_read_row = 5'd0;
    logic [6:0] i_read_col = 7'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [4:0] o_cursor_row;
    logic [6:0] o_cursor_col;
    logic       o_scrolled;
    logic [7:0] o_cell_char;
    logic [7:0] o_cell_attr;

    console_shadow shadow;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     settings = 0;
    longint cycles = 0;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col),
        .o_scrolled  (o_scrolled),
        .o_cell_char (o_cell_char),
        .o_cell_attr (o_cell_attr)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_status({o_cursor_row, o_cursor_col, o_scrolled,
                                 o_cell_char, o_cell_attr});
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, shadow.status_q.size());
            $display("text_console_writer_core: mismatch");
            $finish;
        end
    end

    task automatic send_command(input logic [1:0] mode, input logic [7:0] ch,
                                input logic [4:0] row, input logic [6:0] col);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_char_code <= ch;
        i_read_row  <= row;
        i_read_col  <= col;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.accept_command(mode, ch, row, col);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.status_q.size() != 0);
    endtask

    task automatic set_attribute(input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow.attribute = value;
        settings++;
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [7:0] attr);
        int         n;
        int         clear_at;
        int         pick;
        logic [1:0] mode;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
        set_attribute(attr);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        clear_at = $urandom_range(300, PHASE_ITEMS - 1);
        for (n = 0; n < PHASE_ITEMS; n++) begin
            ch   = 8'($urandom_range(0, 255));
            row  = 5'($urandom_range(0, 31));
            col  = 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (n == clear_at) begin
                mode = MODE_CLEAR;
            end else if (pick < 24) begin
                mode = MODE_READ;
                if ($urandom_range(0, 99) < 85) begin
                    row = 5'($urandom_range(0, ROWS - 1));
                    col = 7'($urandom_range(0, COLUMNS - 1));
                end
            end else if (pick < 27) begin
                mode = MODE_UNUSED;
            end else begin
                mode = MODE_PUT;
                pick = $urandom_range(0, 99);
                if (pick < 18)
                    ch = NEWLINE_CODE;
                else if (pick < 28)
                    ch = BACKSPACE_CODE;
                else if (pick < 38)
                    ch = TAB_CODE;
            end
            send_command(mode, ch, row, col);
        end
        wait_for_results();
    endtask

    initial begin
        shadow = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset contents, the last cell and reads outside the screen.
        send_command(MODE_READ, 8'h00, 5'd0, 7'd0);
        send_command(MODE_READ, 8'hFF, 5'd24, 7'd79);
        send_command(MODE_READ, 8'hFF, 5'd31, 7'd127);
        send_command(MODE_READ, 8'h00, 5'd25, 7'd0);
        send_command(MODE_READ, 8'h00, 5'd0, 7'd80);
        wait_for_results();
        set_attribute(8'hA5);

        send_command(MODE_PUT, 8'h41, 5'd0, 7'd0);
        send_command(MODE_PUT, 8'hFF, 5'd0, 7'd0);
        send_command(MODE_PUT, 8'h00, 5'd0, 7'd0);
        send_command(MODE_PUT, BACKSPACE_CODE, 5'd0, 7'd0);
        send_command(MODE_READ, 8'h00, 5'd0, 7'd2);
        send_command(MODE_READ, 8'h00, 5'd0, 7'd1);
        send_command(MODE_PUT, TAB_CODE, 5'd0, 7'd0);
        send_command(MODE_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_command(MODE_UNUSED, 8'hFF, 5'd31, 7'd127);
        send_command(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
        send_command(MODE_PUT, BACKSPACE_CODE, 5'd0, 7'd0);
        send_command(MODE_READ, 8'h00, 5'd0, 7'd0);
        send_command(MODE_PUT, 8'h7E, 5'd0, 7'd0);
        send_command(MODE_READ, 8'h00, 5'd0, 7'd0);
        wait_for_results();

        run_phase(14, 61, 8'h00);
        run_phase(61, 14, 8'hFF);
        run_phase(0, 0, 8'($urandom_range(1, 254)));
        repeat (50) @(posedge i_clk);

        $display("Checked %0d results with %0d scrolls, %0d clears and %0d cell reads",
                 shadow.checked, shadow.scrolls, shadow.clears, shadow.reads);
        $display("across %0d attribute settings; %0d mismatches, %0d results missing.",
                 settings, shadow.mismatches, shadow.status_q.size());
        if (shadow.mismatches == 0 && shadow.status_q.size() == 0) begin
            $display("text_console_writer_core: match");
        end else begin
            $display("text_console_writer_core: mismatch");
        end
        $finish;
    end

endmodule
